@@ hw/rtl/first_fit_heap_allocator_assert.svh @@
// Assertion macros used by the heap allocator's top level.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define FFHA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/ffha_pkg.sv @@
// Types and constants shared by the heap allocator's controller, datapath and top level.
`default_nettype none

package ffha_pkg;

   // Header layout: 8 bytes a header, bit 0 marks a free block
   localparam int unsigned HDR_BYTES   = 8;
   localparam int unsigned MIN_SPLIT   = 16;
   localparam int unsigned MIN_REQUEST = 8;
   localparam int unsigned HDR_W       = 16;
   // Rounded request size holds up to 65536
   localparam int unsigned SIZE_W      = 17;
   localparam logic        REQ_ALLOC   = 1'b0;
   localparam logic        REQ_FREE    = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [15:0] request_bytes;
      logic [14:0] block_offset;
   } req_beat_type;

   typedef struct packed {
      logic [14:0] payload_offset;
      logic        status;
   } rsp_beat_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_ACCEPT,
      OP_WALK_RD,
      OP_HDR,
      OP_MERGE_RD,
      OP_MERGE,
      OP_COMMIT,
      OP_SPLIT,
      OP_EXTEND,
      OP_FREE_RD,
      OP_FREE_WR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic free_ok;
      logic off_lt_top;
      logic rd_free;
      logic next_lt_top;
      logic fits;
      logic split;
      logic rsp_busy;
   } dp_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/ffha_datapath.sv @@
// Datapath of the heap allocator: header store, walk registers, heap top and result register.
`default_nettype none

module ffha_datapath #(
   parameter int unsigned HEAP_BYTES = 32768
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ffha_pkg::req_beat_type req_payload,
   input  ffha_pkg::dp_cmd_type   cmd,
   output ffha_pkg::dp_status_type dp_status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ffha_pkg::rsp_beat_type rsp_payload
);
   import ffha_pkg::*;

   localparam int unsigned DEPTH = HEAP_BYTES / 8;
   localparam int unsigned IW    = $clog2(DEPTH);
   localparam int unsigned OW    = $clog2(HEAP_BYTES) + 1;
   localparam int unsigned SW    = ((OW > SIZE_W) ? OW : SIZE_W) + 2;

   localparam logic [SW-1:0] HDR_W_S    = SW'(HDR_BYTES);
   localparam logic [SW-1:0] SPLIT_S    = SW'(MIN_SPLIT);
   localparam logic [SW-1:0] DEPTH_S    = SW'(DEPTH);
   localparam logic [SW-1:0] HEAP_LIMIT = SW'(HEAP_BYTES);

   // Header store, one entry for each 8 bytes of heap
   logic [HDR_W-1:0] mem [DEPTH];

   logic [SW-1:0]     off_ff, next_ff, pay_ff, free_off_ff;
   logic [SIZE_W-1:0] n_ff;
   logic [OW-1:0]     top_ff;
   logic              is_free_ff, free_ok_ff;
   logic [HDR_W-1:0]  rd_data_ff;
   logic [14:0]       res_off_ff;
   logic              res_fail_ff;
   logic              rsp_valid_ff;
   rsp_beat_type      rsp_data_ff;

   logic [SIZE_W-1:0] want;
   logic [SIZE_W-1:0] n_in;
   logic [SW-1:0]     boff_w;
   logic              free_ok_in;
   logic [SW-1:0]     top_w, n_w, rd_size;
   logic [SW-1:0]     hdr_next, merge_next, merge_pay;
   logic [SW-1:0]     left, rem_off, rem_size, ext_end, res_base;
   logic              fits, split, ext_fail, rem_in_range;
   logic [IW-1:0]     rd_idx, wr_idx;
   logic              wr_en;
   logic [HDR_W-1:0]  wr_data;

   // Round the request up to whole 8-byte units, zero counting as one unit
   always_comb begin
      want = SIZE_W'(req_payload.request_bytes);
      if (want == '0) begin
         want = SIZE_W'(MIN_REQUEST);
      end
      n_in = (want + SIZE_W'(7)) & ~SIZE_W'(7);
   end

   // Free target: header sits 8 bytes below the payload and must lie in the store
   assign boff_w     = SW'(req_payload.block_offset);
   assign free_ok_in = (boff_w >= HDR_W_S) && (((boff_w - HDR_W_S) >> 3) < DEPTH_S);

   // Walk arithmetic
   assign top_w        = SW'(top_ff);
   assign n_w          = SW'(n_ff);
   assign rd_size      = SW'({rd_data_ff[HDR_W-1:1], 1'b0});
   assign hdr_next     = off_ff + HDR_W_S + rd_size;
   assign merge_next   = next_ff + HDR_W_S + rd_size;
   assign merge_pay    = pay_ff + HDR_W_S + rd_size;
   assign fits         = pay_ff >= n_w;
   assign left         = pay_ff - n_w;
   assign split        = left >= SPLIT_S;
   assign rem_off      = off_ff + HDR_W_S + n_w;
   assign rem_size     = left - HDR_W_S;
   assign rem_in_range = (rem_off >> 3) < DEPTH_S;
   assign ext_end      = top_w + HDR_W_S + n_w;
   assign ext_fail     = ext_end > HEAP_LIMIT;
   assign res_base     = off_ff + HDR_W_S;

   // Select the store read address
   always_comb begin
      case (cmd.op)
         OP_WALK_RD:  rd_idx = off_ff[IW+2:3];
         OP_MERGE_RD: rd_idx = next_ff[IW+2:3];
         OP_FREE_RD:  rd_idx = free_off_ff[IW+2:3];
         default:     rd_idx = '0;
      endcase
   end

   // Select the store write
   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = off_ff[IW+2:3];
      wr_data = pay_ff[HDR_W-1:0] | HDR_W'(1);
      case (cmd.op)
         OP_COMMIT: begin
            wr_en = 1'b1;
            if (fits) begin
               wr_data = split ? n_ff[HDR_W-1:0] : pay_ff[HDR_W-1:0];
            end
         end
         OP_SPLIT: begin
            wr_en   = rem_in_range;
            wr_idx  = rem_off[IW+2:3];
            wr_data = rem_size[HDR_W-1:0] | HDR_W'(1);
         end
         OP_EXTEND: begin
            wr_en   = !ext_fail;
            wr_idx  = top_ff[IW+2:3];
            wr_data = n_ff[HDR_W-1:0];
         end
         OP_FREE_WR: begin
            wr_en   = 1'b1;
            wr_idx  = free_off_ff[IW+2:3];
            wr_data = rd_data_ff | HDR_W'(1);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Header store with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   // Control state: heap top and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= OW'(HDR_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_EXTEND && !ext_fail) begin
            top_ff <= ext_end[OW-1:0];
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Walk and result registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: begin
            n_ff        <= n_in;
            off_ff      <= HDR_W_S;
            is_free_ff  <= (req_payload.req_type == REQ_FREE);
            free_ok_ff  <= free_ok_in;
            free_off_ff <= boff_w - HDR_W_S;
            res_off_ff  <= '0;
            res_fail_ff <= 1'b0;
         end
         OP_HDR: begin
            pay_ff  <= rd_size;
            next_ff <= hdr_next;
            if (!rd_data_ff[0]) begin
               off_ff <= hdr_next;
            end
         end
         OP_MERGE: begin
            pay_ff  <= merge_pay;
            next_ff <= merge_next;
         end
         OP_COMMIT: begin
            if (fits) begin
               res_off_ff <= res_base[14:0];
            end else begin
               off_ff <= next_ff;
            end
         end
         OP_EXTEND: begin
            if (ext_fail) begin
               res_fail_ff <= 1'b1;
            end else begin
               res_off_ff <= top_w[14:0] + 15'(HDR_BYTES);
            end
         end
         default: begin
         end
      endcase
      if (cmd.load_rsp) begin
         rsp_data_ff.payload_offset <= res_off_ff;
         rsp_data_ff.status         <= res_fail_ff;
      end
   end

   // Status towards the controller
   always_comb begin
      dp_status.is_free     = is_free_ff;
      dp_status.free_ok     = free_ok_ff;
      dp_status.off_lt_top  = off_ff < top_w;
      dp_status.rd_free     = rd_data_ff[0];
      dp_status.next_lt_top = next_ff < top_w;
      dp_status.fits        = fits;
      dp_status.split       = split;
      dp_status.rsp_busy    = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ffha_ctrl.sv @@
// Controller of the heap allocator: sequences the header walk, merges, splits, heap extension and frees.
`default_nettype none

module ffha_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ffha_pkg::dp_status_type dp_status,
   output ffha_pkg::dp_cmd_type    cmd
);
   import ffha_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_WTEST,
      S_WHDR,
      S_MTEST,
      S_MHDR,
      S_COMMIT,
      S_SPLIT,
      S_EXTEND,
      S_FREE_RD,
      S_FREE_WR,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff;

   // Next state and datapath command
   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_IDLE;
      cmd.load_rsp = 1'b0;
      case (state_ff)
         // Take a beat only at an edge where the input is not stalled
         S_IDLE: begin
            if (req_valid && !stall_ff) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!dp_status.is_free) begin
               state_in = S_WTEST;
            end else if (dp_status.free_ok) begin
               state_in = S_FREE_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         // Visit the next block, or extend the heap past the last one
         S_WTEST: begin
            if (dp_status.off_lt_top) begin
               cmd.op   = OP_WALK_RD;
               state_in = S_WHDR;
            end else begin
               state_in = S_EXTEND;
            end
         end
         S_WHDR: begin
            cmd.op   = OP_HDR;
            state_in = dp_status.rd_free ? S_MTEST : S_WTEST;
         end
         // Absorb the free blocks that follow directly
         S_MTEST: begin
            if (dp_status.next_lt_top) begin
               cmd.op   = OP_MERGE_RD;
               state_in = S_MHDR;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_MHDR: begin
            if (dp_status.rd_free) begin
               cmd.op   = OP_MERGE;
               state_in = S_MTEST;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.op = OP_COMMIT;
            if (!dp_status.fits) begin
               state_in = S_WTEST;
            end else if (dp_status.split) begin
               state_in = S_SPLIT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SPLIT: begin
            cmd.op   = OP_SPLIT;
            state_in = S_FINISH;
         end
         S_EXTEND: begin
            cmd.op   = OP_EXTEND;
            state_in = S_FINISH;
         end
         S_FREE_RD: begin
            cmd.op   = OP_FREE_RD;
            state_in = S_FREE_WR;
         end
         S_FREE_WR: begin
            cmd.op   = OP_FREE_WR;
            state_in = S_FINISH;
         end
         // Hand the result to the output register once it has room
         S_FINISH: begin
            if (!dp_status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and the registered stall
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stall_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != S_IDLE);
      end
   end

   assign req_stall = stall_ff;

endmodule

`default_nettype wire

@@ hw/rtl/first_fit_heap_allocator.sv @@
// First-fit heap allocator, top level: controller, datapath and assertions.
// An allocate beat walks the block headers from offset 8 up to the heap top, one header-store
// read per block, merging runs of free blocks on the way. For each block it tests the offset
// against the heap top and reads the header; it commits a free run, reusing it with an optional
// split if it fits, and past the last block extends the heap top or runs out of memory. Rate is
// set by the one header read a cycle and the walk sequencer. A free beat reads one header and
// writes it back with the free bit set, skipping both when its offset is below 8 or its header
// lies past the store. The result register lets the next beat start while a result is still
// stalled; a beat that has finished waits in its last cycle until that register has room.
// Headers are not cleared at reset; a free of an address never handed out may corrupt the walk.
`default_nettype none

`include "first_fit_heap_allocator_assert.svh"

module first_fit_heap_allocator #(
   parameter int unsigned HEAP_BYTES = 32768
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ffha_pkg::req_beat_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ffha_pkg::rsp_beat_type rsp_payload
);
   import ffha_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type dp_status;
   logic          rsp_oom;
   logic          cmd_quiet;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   ffha_datapath #(
      .HEAP_BYTES (HEAP_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   assign rsp_oom   = rsp_valid && rsp_payload.status;
   assign cmd_quiet = (cmd.op == OP_IDLE) && !cmd.load_rsp;

   // A taken beat keeps the block busy in the next cycle
   `FFHA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "stall missing")
   // A failed allocation never reports an offset
   `FFHA_ASSERT_NOW(a_fail_null, rsp_oom, rsp_payload.payload_offset == '0, "oom with offset")
   // While idle with nothing offered the datapath stays quiet
   `FFHA_ASSERT_NOW(a_idle_quiet, !req_stall && !req_valid, cmd_quiet, "idle datapath command")

endmodule

`default_nettype wire
